// ===== design/axs_pkg.sv =====
// Package: AES tables, round functions and controller/datapath command types.
package axs_pkg;

  localparam int BLOCK_W   = 128;
  localparam int ROUNDS    = 10;
  localparam int CNT_W     = 4;
  localparam logic [7:0] TWEAK_POLY = 8'h87;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [ROUNDS] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  typedef logic [7:0] inv_box_t [256];

  // Invert the forward box at elaboration
  function automatic inv_box_t build_inv();
    inv_box_t t;
    for (int i = 0; i < 256; i++) begin
      t[FWD_BOX[i]] = i[7:0];
    end
    return t;
  endfunction

  localparam inv_box_t INV_BOX = build_inv();

  typedef struct packed {
    logic             load;
    logic             key_step;
    logic             key_last;
    logic             rnd_step;
    logic             rnd_last;
    logic             finish;
    logic [CNT_W-1:0] cnt;
  } axs_cmd_t;

  typedef struct packed {
    logic dec_mode;
    logic out_busy;
  } axs_status_t;

  // Byte i of a block, byte 0 most significant
  function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiply by one of the MixColumns constants
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] a2, a4, a8, p;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    p  = (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00) ^ (m[2] ? a4 : 8'h00) ^ (m[3] ? a8 : 8'h00);
    return p;
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127-8*(r+4*c) -: 8] = INV_BOX[get_b(s, r + 4*((c - r + 4) & 3))];
        end else begin
          t[127-8*(r+4*c) -: 8] = FWD_BOX[get_b(s, r + 4*((c + r) & 3))];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [3:0]   m [4];
    logic [7:0]   v;
    if (inv) begin
      m = '{4'd14, 4'd11, 4'd13, 4'd9};
    end else begin
      m = '{4'd2, 4'd3, 4'd1, 4'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) begin
          v = v ^ gmul(get_b(s, 4*c + k), m[(k - r + 4) & 3]);
        end
        t[127-8*(4*c+r) -: 8] = v;
      end
    end
    return t;
  endfunction

  // Rotated, substituted last word plus round constant
  function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rc);
    return {FWD_BOX[w[23:16]] ^ rc, FWD_BOX[w[15:8]], FWD_BOX[w[7:0]], FWD_BOX[w[31:24]]};
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ key_g(k[31:0], rc);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] key_prev(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ key_g(p3, rc);
    return {p0, p1, p2, p3};
  endfunction

endpackage

// ===== design/axs_ifs.sv =====
// Stream interfaces for the command and result channels.
interface axs_cmd_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        decrypt;
  logic [4:0]  nonce_length;
  logic [63:0] nonce_high;
  logic [63:0] nonce_low;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, action, decrypt, nonce_length, nonce_high, nonce_low,
                  block_high, block_low, input ready);
  modport sink (input valid, action, decrypt, nonce_length, nonce_high, nonce_low,
                block_high, block_low, output ready);
endinterface

interface axs_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

// ===== design/axs_ctrl.sv =====
// Controller: sequences load, key run, rounds and finish for one item.
module axs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_action,
  input  axs_pkg::axs_status_t status,
  output logic                 in_ready,
  output axs_pkg::axs_cmd_t    cmd
);
  import axs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEYX = 2'd1;
  localparam logic [1:0] ST_RND  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ROUNDS - 1);

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // Decode state into datapath commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = (in_action && status.dec_mode) ? ST_KEYX : ST_RND;
        end
      end
      ST_KEYX: begin
        cmd.key_step = 1'b1;
        cmd.key_last = (cnt == LAST_CNT);
        cnt_next     = cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          cnt_next   = '0;
          state_next = ST_RND;
        end
      end
      ST_RND: begin
        cmd.rnd_step = 1'b1;
        cmd.rnd_last = (cnt == LAST_CNT);
        cnt_next     = cnt + 1'b1;
        if (cnt == LAST_CNT) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== design/axs_datapath.sv =====
// Datapath: AES state, round key, tweak and result register.
module axs_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  axs_pkg::axs_cmd_t    cmd,
  input  logic [127:0]         key,
  input  logic                 action,
  input  logic                 decrypt,
  input  logic [4:0]           nonce_length,
  input  logic [127:0]         nonce,
  input  logic [127:0]         block,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [127:0]         result,
  output axs_pkg::axs_status_t status
);
  import axs_pkg::*;

  logic [127:0] aes_state, rk, tweak;
  logic         dec_mode, item_inv, item_data;
  logic [127:0] nonce_pad, load_val;
  logic [127:0] rk_fwd, rk_bwd, st_fwd, st_bwd, step_val;
  logic [CNT_W-1:0] inv_idx;

  // Zero nonce bytes past the length
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      nonce_pad[127-8*i -: 8] = (5'(i) < nonce_length) ? nonce[127-8*i -: 8] : 8'h00;
    end
  end

  assign load_val = action ? (block ^ tweak) : nonce_pad;
  assign inv_idx  = CNT_W'(ROUNDS - 1) - cmd.cnt;

  // One round either way
  always_comb begin
    rk_fwd = key_next(rk, RCON[cmd.cnt]);
    rk_bwd = key_prev(rk, RCON[inv_idx]);
    st_fwd = sub_shift(aes_state, 1'b0);
    if (!cmd.rnd_last) begin
      st_fwd = mix_cols(st_fwd, 1'b0);
    end
    st_fwd = st_fwd ^ rk_fwd;
    st_bwd = sub_shift(aes_state, 1'b1) ^ rk_bwd;
    if (!cmd.rnd_last) begin
      st_bwd = mix_cols(st_bwd, 1'b1);
    end
    step_val = item_inv ? st_bwd : st_fwd;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rk        <= key;
      item_data <= action;
      if (action && dec_mode) begin
        aes_state <= load_val;
      end else begin
        aes_state <= load_val ^ key;
      end
    end else if (cmd.key_step) begin
      rk <= rk_fwd;
      if (cmd.key_last) begin
        aes_state <= aes_state ^ rk_fwd;
      end
    end else if (cmd.rnd_step) begin
      rk        <= item_inv ? rk_bwd : rk_fwd;
      aes_state <= step_val;
    end
    if (cmd.finish && item_data) begin
      result <= aes_state ^ tweak;
    end
  end

  // Control state: tweak, direction, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tweak     <= '0;
      dec_mode  <= 1'b0;
      item_inv  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        item_inv <= action && dec_mode;
        if (!action) begin
          dec_mode <= decrypt;
        end
      end
      if (cmd.finish) begin
        if (item_data) begin
          out_valid <= 1'b1;
          tweak     <= {tweak[126:0], 1'b0} ^ {120'd0, (tweak[127] ? TWEAK_POLY : 8'h00)};
        end else begin
          tweak <= aes_state;
        end
      end
    end
  end

  assign status.dec_mode = dec_mode;
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== design/aes_xex_sector_cipher_top.sv =====
// Top level: AES-128 XEX sector cipher with APB key registers.
//
//  channel | dir | handshake   | content
//  cmd     | in  | valid/ready | action, decrypt, nonce_length, nonce, block
//  rsp     | out | valid/ready | result_high, result_low (data items only)
//  apb     | in  | psel/penable| key_high at 0x0, key_low at 0x8
//
// Encrypting items (start, or data in encrypt mode) go through load, ten
// rounds of the shared round unit and finish. Data items in decrypt mode
// first run the key schedule forward to the last round key. Reset clears
// the tweak to zero and selects encrypt. The result register holds an item
// until taken; the finish step waits while it is full.
module aes_xex_sector_cipher_top (
  input  logic        clk,
  input  logic        rst,
  axs_cmd_if.sink     cmd,
  axs_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import axs_pkg::*;

  logic [63:0]  key_high, key_low;
  axs_cmd_t     ctl_cmd;
  axs_status_t  status;
  logic [127:0] result;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        key_low <= pwdata;
      end else begin
        key_high <= pwdata;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[3] ? key_low : key_high;

  axs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_action (cmd.action),
    .status    (status),
    .in_ready  (cmd.ready),
    .cmd       (ctl_cmd)
  );

  axs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ctl_cmd),
    .key          ({key_high, key_low}),
    .action       (cmd.action),
    .decrypt      (cmd.decrypt),
    .nonce_length (cmd.nonce_length),
    .nonce        ({cmd.nonce_high, cmd.nonce_low}),
    .block        ({cmd.block_high, cmd.block_low}),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .result       (result),
    .status       (status)
  );

  assign rsp.result_high = result[127:64];
  assign rsp.result_low  = result[63:0];

endmodule

// ===== tb/sv/aes_xex_sector_cipher_top_test.sv =====
// Self-checking testbench for the AES-128 XEX sector cipher top level.
module aes_xex_sector_cipher_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 40;
  localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
  localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // Tracks key, tweak and direction, and holds the cipher results still owed
  class xex_scoreboard;
    logic [7:0]   inv_sbox [256];
    logic [127:0] key;
    logic [127:0] tweak;
    bit           dec_mode;
    logic [127:0] owed [$];
    int           errors;
    int           checked;
    int           starts;

    function new();
      for (int i = 0; i < 256; i++) begin
        inv_sbox[axs_pkg::FWD_BOX[i]] = i[7:0];
      end
      key = '0;
      tweak = '0;
      dec_mode = 0;
      errors = 0;
      checked = 0;
      starts = 0;
    endfunction

    function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      while (b != 0) begin
        if (b[0]) p = p ^ a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        b = b >> 1;
      end
      return p;
    endfunction

    function logic [127:0] sub_shift(logic [127:0] s, bit inv);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          if (inv) begin
            t[127-8*(r+4*c) -: 8] = inv_sbox[s[127-8*(r+4*((c-r+4)&3)) -: 8]];
          end else begin
            t[127-8*(r+4*c) -: 8] = axs_pkg::FWD_BOX[s[127-8*(r+4*((c+r)&3)) -: 8]];
          end
        end
      end
      return t;
    endfunction

    function logic [127:0] mix(logic [127:0] s, bit inv);
      logic [7:0] m [4];
      logic [7:0] a [4];
      logic [7:0] v;
      if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
      else m = '{8'd2, 8'd3, 8'd1, 8'd1};
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = s[127-8*(4*c+r) -: 8];
        for (int r = 0; r < 4; r++) begin
          v = 8'h00;
          for (int k = 0; k < 4; k++) v = v ^ gf_mul(a[k], m[(k-r+4)&3]);
          s[127-8*(4*c+r) -: 8] = v;
        end
      end
      return s;
    endfunction

    function logic [127:0] aes128(logic [127:0] din, bit inv);
      logic [127:0] rk [11];
      logic [127:0] s;
      logic [31:0]  g, w0, w1, w2, w3;
      logic [7:0]   rc;
      rk[0] = key;
      rc = 8'h01;
      for (int r = 1; r <= 10; r++) begin
        g = {axs_pkg::FWD_BOX[rk[r-1][23:16]] ^ rc, axs_pkg::FWD_BOX[rk[r-1][15:8]],
             axs_pkg::FWD_BOX[rk[r-1][7:0]], axs_pkg::FWD_BOX[rk[r-1][31:24]]};
        w0 = rk[r-1][127:96] ^ g;
        w1 = rk[r-1][95:64] ^ w0;
        w2 = rk[r-1][63:32] ^ w1;
        w3 = rk[r-1][31:0] ^ w2;
        rk[r] = {w0, w1, w2, w3};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      s = din;
      if (!inv) begin
        s = s ^ rk[0];
        for (int r = 1; r < 10; r++) s = mix(sub_shift(s, 0), 0) ^ rk[r];
        s = sub_shift(s, 0) ^ rk[10];
      end else begin
        s = s ^ rk[10];
        for (int r = 9; r >= 1; r--) s = mix(sub_shift(s, 1) ^ rk[r], 1);
        s = sub_shift(s, 1) ^ rk[0];
      end
      return s;
    endfunction

    function void note_item(logic act, logic dec, logic [4:0] len, logic [63:0] nh,
                            logic [63:0] nl, logic [63:0] bh, logic [63:0] bl);
      logic [127:0] pad;
      int n;
      bit carry;
      if (act == ACT_START) begin
        dec_mode = dec;
        n = (len > 16) ? 16 : len;
        pad = {nh, nl};
        for (int i = n; i < 16; i++) pad[127-8*i -: 8] = 8'h00;
        tweak = aes128(pad, 0);
        starts++;
      end else begin
        owed.push_back(aes128({bh, bl} ^ tweak, dec_mode) ^ tweak);
        // Double the tweak in GF(2^128)
        carry = tweak[127];
        tweak = tweak << 1;
        if (carry) tweak[7:0] = tweak[7:0] ^ 8'h87;
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch: %s got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(logic [63:0] rh, logic [63:0] rl);
      logic [127:0] want;
      if (owed.size() == 0) begin
        report("unexpected result", rh, 64'h0);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (rh !== want[127:64]) report("result_high", rh, want[127:64]);
      if (rl !== want[63:0]) report("result_low", rl, want[63:0]);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  axs_cmd_if cmd_ch ();
  axs_rsp_if rsp_ch ();

  aes_xex_sector_cipher_top dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  xex_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(logic act, logic dec, logic [4:0] len, logic [63:0] nh,
                           logic [63:0] nl, logic [63:0] bh, logic [63:0] bl);
    if ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.action <= act;
    cmd_ch.decrypt <= dec;
    cmd_ch.nonce_length <= len;
    cmd_ch.nonce_high <= nh;
    cmd_ch.nonce_low <= nl;
    cmd_ch.block_high <= bh;
    cmd_ch.block_low <= bl;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_item(act, dec, len, nh, nl, bh, bl);
    items_sent++;
  endtask

  task automatic send_data(logic [63:0] bh, logic [63:0] bl);
    send_item(ACT_DATA, 1'($urandom_range(1)), 5'($urandom), rand64(), rand64(), bh, bl);
  endtask

  task automatic send_start(logic dec, logic [4:0] len, logic [63:0] nh, logic [63:0] nl);
    send_item(ACT_START, dec, len, nh, nl, rand64(), rand64());
  endtask

  // Lower valid and wait until every owed result is back and the block is quiet
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_KEY_HIGH) sb.key[127:64] = data;
    else sb.key[63:0] = data;
  endtask

  // Mostly well-formed sectors with random content, some stray items
  task automatic run_sectors(int count);
    int stop;
    int nblk;
    logic [4:0] len;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(9) == 0) begin
        send_item(1'($urandom_range(1)), 1'($urandom_range(1)), 5'($urandom), rand64(),
                  rand64(), rand64(), rand64());
      end else begin
        len = ($urandom_range(7) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
        send_start(1'($urandom_range(1)), len, rand64(), rand64());
        nblk = $urandom_range(6, 1);
        repeat (nblk) send_data(rand64(), rand64());
      end
    end
  endtask

  // Take results, stalling at random or for a requested long stretch
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.result_high,
                                                                rsp_ch.result_low);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_START;
    cmd_ch.decrypt = 1'b0;
    cmd_ch.nonce_length = '0;
    cmd_ch.nonce_high = '0;
    cmd_ch.nonce_low = '0;
    cmd_ch.block_high = '0;
    cmd_ch.block_low = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: data before any start, nonce length extremes, ignored fields
    send_data('0, '0);
    send_data('1, '1);
    send_start(1'b0, 5'd0, '1, '1);
    send_data('0, '0);
    send_data('1, '1);
    send_start(1'b0, 5'd16, '1, '1);
    send_data(rand64(), rand64());
    send_start(1'b1, 5'd17, rand64(), rand64());
    send_data('0, '0);
    send_data('1, '1);
    send_start(1'b0, 5'd31, '0, '0);
    send_data(rand64(), rand64());
    send_start(1'b1, 5'd8, rand64(), rand64());
    send_data('1, '0);
    send_item(ACT_START, 1'b0, 5'd1, '1, '1, '1, '1);
    send_item(ACT_DATA, 1'b1, 5'd31, '1, '1, rand64(), rand64());
    send_item(ACT_DATA, 1'b1, 5'd0, '0, '0, '0, '1);
    drain();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin
          write_reg(ADDR_KEY_HIGH, '1);
          write_reg(ADDR_KEY_LOW, '1);
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        2: begin
          write_reg(ADDR_KEY_HIGH, rand64());
          write_reg(ADDR_KEY_LOW, rand64());
          tx_idle_pct = 78;
          rx_stall_pct = 0;
        end
        3: begin
          write_reg(ADDR_KEY_HIGH, '0);
          write_reg(ADDR_KEY_LOW, '0);
          tx_idle_pct = 0;
          rx_stall_pct = 78;
        end
        4: begin
          write_reg(ADDR_KEY_HIGH, rand64());
          write_reg(ADDR_KEY_LOW, rand64());
          tx_idle_pct = 31;
          rx_stall_pct = 31;
        end
        default: begin
          write_reg(ADDR_KEY_HIGH, rand64());
          write_reg(ADDR_KEY_LOW, rand64());
          tx_idle_pct = 0;
          rx_stall_pct = 0;
          hold_left = 400;
        end
      endcase
      // Key change keeps the running tweak
      send_data(rand64(), rand64());
      run_sectors(105);
      drain();
    end

    $display("covered %0d items: %0d sector starts, %0d results checked", items_sent,
             sb.starts, sb.checked);
    $display("five key settings, four idle patterns and one long result stall");
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.owed.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/axs_pkg.sv
design/axs_ifs.sv
design/axs_ctrl.sv
design/axs_datapath.sv
design/aes_xex_sector_cipher_top.sv
tb/sv/aes_xex_sector_cipher_top_test.sv
